### hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, error codes and the character-to-sixtet map for the
// base64url stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_INVALID   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_AFTER_PAD = 2'd3;

    localparam logic [7:0] PAD_RESET = 8'd61;

    // Results caused by one input item, drained one per output item.
    typedef struct packed {
        logic [23:0] group;  // bytes most significant first
        logic [1:0]  count;  // number of results, 1..3
        logic [1:0]  err;    // nonzero: single error result
    } t_bundle;

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] char_to_sixtet(input logic [7:0] c);
        logic [6:0] sx;
        sx = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a) begin
            sx = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            sx = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            sx = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2d) begin
            sx = 7'd62;
        end else if (c == 8'h5f) begin
            sx = 7'd63;
        end
        return sx;
    endfunction

endpackage

### hdl/base64url_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top
// Results: each taken item's results are registered into the result queue.
// Throughput: one character per cycle unless the two-deep result queue stalls
// the input; items yield 0..3 results each, popped one per cycle on i_ready.
// Reset: synchronous active-low; clears group state, queue, pad char to '='.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic [1:0] o_error_code,
    output logic       o_run_end
);

    logic [7:0]  r_pad;
    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic        r_pad_cnt, n_pad_cnt;
    logic        r_padded, n_padded;

    b64d_pkg::t_bundle r_hd, r_tl, n_hd, n_tl, w_new;
    logic        r_hd_vld, r_tl_vld, n_hd_vld, n_tl_vld;
    logic [1:0]  r_idx, n_idx;

    logic        w_acc_in;
    logic        w_push;
    logic        w_pop;
    logic        w_out_acc;
    logic [6:0]  w_sx;
    logic        w_is_pad;
    logic        w_emit;
    logic [23:0] w_grp;
    logic [1:0]  w_cnt;
    logic        w_err;
    logic [1:0]  w_code;
    logic        w_adv;

    assign o_ready  = !r_tl_vld;
    assign w_acc_in = i_valid && o_ready;

    // ---------------- decode ----------------
    always_comb begin
        w_sx     = b64d_pkg::char_to_sixtet(i_char_in);
        w_is_pad = (i_char_in == r_pad);
        w_emit   = 1'b0;
        w_grp    = {r_acc, 6'd0};
        w_cnt    = 2'd3;
        w_err    = 1'b0;
        w_code   = b64d_pkg::ERR_NONE;
        w_adv    = 1'b0;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_pad_cnt = r_pad_cnt;
        n_padded = r_padded;

        priority if (r_padded) begin
            w_err  = 1'b1;
            w_code = b64d_pkg::ERR_AFTER_PAD;
        end else if (r_pad_cnt) begin
            if (r_pos == 2'd3 && w_is_pad) begin
                w_emit = 1'b1;
                w_cnt  = 2'd1;
            end else begin
                w_err  = 1'b1;
                w_code = b64d_pkg::ERR_INVALID;
            end
        end else if (!w_sx[6]) begin
            if (r_pos == 2'd3) begin
                w_emit = 1'b1;
                w_grp  = {r_acc, w_sx[5:0]};
            end else begin
                w_adv = 1'b1;
                n_acc = {r_acc[11:0], w_sx[5:0]};
                n_pos = r_pos + 2'd1;
            end
        end else if (w_is_pad && r_pos[1]) begin
            if (r_pos == 2'd3) begin
                w_emit = 1'b1;
                w_cnt  = 2'd2;
            end else begin
                w_adv     = 1'b1;
                n_acc     = {r_acc[11:0], 6'd0};
                n_pos     = 2'd3;
                n_pad_cnt = 1'b1;
            end
        end else begin
            w_err  = 1'b1;
            w_code = b64d_pkg::ERR_INVALID;
        end

        // valid character or first pad that leaves the group open at stream end
        if (w_adv && i_last_char) begin
            w_err  = 1'b1;
            w_code = b64d_pkg::ERR_TRUNCATED;
        end

        if (w_err) begin
            n_acc     = '0;
            n_pos     = '0;
            n_pad_cnt = 1'b0;
            n_padded  = 1'b0;
        end else if (w_emit) begin
            n_acc     = '0;
            n_pos     = '0;
            n_pad_cnt = 1'b0;
            n_padded  = (w_cnt != 2'd3) && !i_last_char;
        end

        w_new.group = w_grp;
        w_new.count = w_err ? 2'd1 : w_cnt;
        w_new.err   = w_code;
    end

    assign w_push = w_acc_in && (w_emit || w_err);

    // ---------------- result queue ----------------
    assign o_valid   = r_hd_vld;
    assign w_out_acc = r_hd_vld && i_ready;
    assign w_pop     = w_out_acc && (r_idx == r_hd.count - 2'd1);

    always_comb begin
        n_hd     = r_hd;
        n_tl     = r_tl;
        n_hd_vld = r_hd_vld;
        n_tl_vld = r_tl_vld;
        n_idx    = r_idx;
        if (w_pop) begin
            n_idx = '0;
            if (r_tl_vld) begin
                n_hd     = r_tl;
                n_tl     = w_new;
                n_tl_vld = w_push;
            end else begin
                n_hd     = w_new;
                n_hd_vld = w_push;
            end
        end else begin
            if (w_out_acc) begin
                n_idx = r_idx + 2'd1;
            end
            if (w_push) begin
                if (!r_hd_vld) begin
                    n_hd     = w_new;
                    n_hd_vld = 1'b1;
                end else begin
                    n_tl     = w_new;
                    n_tl_vld = 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_idx)
            2'd0:    o_out_byte = r_hd.group[23:16];
            2'd1:    o_out_byte = r_hd.group[15:8];
            default: o_out_byte = r_hd.group[7:0];
        endcase
        if (r_hd.err != b64d_pkg::ERR_NONE) begin
            o_out_byte = 8'd0;
        end
    end

    assign o_byte_valid = (r_hd.err == b64d_pkg::ERR_NONE);
    assign o_error_code = r_hd.err;
    assign o_run_end    = (r_idx == r_hd.count - 2'd1);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad     <= b64d_pkg::PAD_RESET;
            r_acc     <= '0;
            r_pos     <= '0;
            r_pad_cnt <= 1'b0;
            r_padded  <= 1'b0;
            r_hd_vld  <= 1'b0;
            r_tl_vld  <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pad <= i_cfg_wr_data;
            end
            if (w_acc_in) begin
                r_acc     <= n_acc;
                r_pos     <= n_pos;
                r_pad_cnt <= n_pad_cnt;
                r_padded  <= n_padded;
            end
            r_hd_vld <= n_hd_vld;
            r_tl_vld <= n_tl_vld;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hd <= n_hd;
        r_tl <= n_tl;
    end

    // ---------------- assertions ----------------
    a_tl_needs_hd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tl_vld |-> r_hd_vld)
        else $error("tail slot filled while head empty");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hd_vld && r_hd.err != b64d_pkg::ERR_NONE) |-> (r_hd.count == 2'd1))
        else $error("error bundle with more than one result");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hd_vld |-> (r_idx < r_hd.count) && (r_hd.count != 2'd0))
        else $error("result index out of range");

    a_pad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_cnt |-> (r_pos == 2'd3) && !r_padded)
        else $error("pad in group without position three");

    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && w_err) |=> (r_pos == 2'd0) && !r_padded && !r_pad_cnt)
        else $error("state not cleared after error");

endmodule
